FILE: src/heightmap_normal_generator_macros.svh
// ----------------------------------------------------------------------------
// Heightmap normal generator assertion macros
// Shared property shorthands for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_GENERATOR_MACROS_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HNM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hnm_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator package
// Shared constants, register codes, configuration and queue entry types.
// ----------------------------------------------------------------------------
package hnm_pkg;

    // Sizing defaults.
    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int QUEUE_DEPTH       = 2;

    // Configuration port layout.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_SELECT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_X         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Z         = 3'd5;

    // Register reset values.
    localparam logic [12:0] RST_MAP_WIDTH      = 13'd256;
    localparam logic [12:0] RST_MAP_HEIGHT     = 13'd256;
    localparam logic [1:0]  RST_CHANNEL_SELECT = 2'd0;
    localparam logic [15:0] RST_HEIGHT_STEP    = 16'd256;
    localparam logic [15:0] RST_STEP_X         = 16'd256;
    localparam logic [15:0] RST_STEP_Z         = 16'd256;

    // Height byte selection codes.
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;
    localparam logic [1:0] CHAN_ALPHA = 2'd3;

    // Input command codes.
    localparam logic CMD_TEXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Current configuration as seen by the front and back ends.
    typedef struct packed {
        logic [12:0] map_width;
        logic [12:0] map_height;
        logic [1:0]  channel_select;
        logic [15:0] height_step;
        logic [15:0] step_x;
        logic [15:0] step_z;
    } t_cfg;

    // One classified vertex request between the front and back ends.
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  hc;
        logic [7:0]  hu;
        logic [7:0]  hr;
        logic [7:0]  hd;
        logic [7:0]  hl;
        logic        u_ok;
        logic        r_ok;
        logic        d_ok;
        logic        l_ok;
        logic        last;
    } t_entry;

    typedef enum logic [2:0] {
        F_IDLE,
        F_READ0,
        F_READ1,
        F_READ2,
        F_WRITE
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIFF,
        B_MUL1,
        B_MUL2,
        B_SHIFT,
        B_SQUARE,
        B_SQRT,
        B_DLOAD,
        B_DIV,
        B_DONE
    } t_back_state;

endpackage

FILE: src/hnm_front.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator front end
// Accepts texel and flush requests, keeps the raster counters and the two
// row buffers, gathers the neighbour heights and queues vertex requests.
// ----------------------------------------------------------------------------
module hnm_front import hnm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_texel,
    output logic        o_push,
    output t_entry      o_entry,
    input  logic        i_full
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    t_front_state r_state, n_state;

    // Raster counters.
    logic [CW-1:0] r_col, r_oc;
    logic [12:0]   r_row;
    logic          r_done;

    // Request payload and gathered neighbours.
    logic          r_is_flush;
    logic [7:0]    r_code;
    logic [7:0]    r_hc, r_hd, r_hr, r_hl;

    // Row buffers with registered read data.
    logic [7:0]    r_newer_mem [MAX_WIDTH];
    logic [7:0]    r_older_mem [MAX_WIDTH];
    logic [7:0]    r_newer_q, r_older_q;
    logic [AW-1:0] newer_addr, older_addr;

    logic [CW-1:0] eff_w, pre_col, cur, cur_inc, cur_dec;
    logic [12:0]   eff_h, pre_row, row_inc;
    logic          pre_done, accept, go, emit, leave, r_ok, l_ok;
    logic [7:0]    code;

    // Map size clamped into its legal range.
    always_comb begin
        if (32'(i_cfg.map_width) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else if (i_cfg.map_width < 13'd2) begin
            eff_w = CW'(2);
        end else begin
            eff_w = CW'(i_cfg.map_width);
        end
        if (i_cfg.map_height > 13'(MAX_HEIGHT)) begin
            eff_h = 13'(MAX_HEIGHT);
        end else if (i_cfg.map_height < 13'd2) begin
            eff_h = 13'd2;
        end else begin
            eff_h = i_cfg.map_height;
        end
    end

    // Counters brought up to date before a request is classified.
    always_comb begin
        pre_col  = r_col;
        pre_row  = r_row;
        pre_done = r_done;
        if (!r_done && r_col >= eff_w) begin
            pre_col = '0;
            pre_row = r_row + 13'd1;
        end
        if (!r_done && pre_row >= eff_h) begin
            pre_done = 1'b1;
        end
    end

    // Height byte of the incoming texel.
    always_comb begin
        case (i_cfg.channel_select)
            CHAN_RED:   code = i_texel[7:0];
            CHAN_GREEN: code = i_texel[15:8];
            CHAN_BLUE:  code = i_texel[23:16];
            CHAN_ALPHA: code = i_texel[31:24];
            default:    code = i_texel[7:0];
        endcase
    end

    assign accept = i_valid && (r_state == F_IDLE);
    assign go     = (i_command == CMD_FLUSH) ? (pre_done && r_oc < eff_w) : !pre_done;

    // Column of the vertex in work and its neighbours.
    assign cur     = r_is_flush ? r_oc : r_col;
    assign cur_inc = cur + CW'(1);
    assign cur_dec = cur - CW'(1);
    assign row_inc = r_row + 13'd1;
    assign r_ok    = cur_inc < eff_w;
    assign l_ok    = (cur != '0);

    // Read addresses for each gathering step.
    always_comb begin
        newer_addr = cur[AW-1:0];
        older_addr = cur[AW-1:0];
        unique case (r_state)
            F_READ1: begin
                newer_addr = cur_inc[AW-1:0];
                older_addr = cur_dec[AW-1:0];
            end
            F_READ2, F_WRITE: begin
                newer_addr = cur_dec[AW-1:0];
            end
            default: begin
                newer_addr = cur[AW-1:0];
            end
        endcase
    end

    // Vertex request built from the gathered heights.
    always_comb begin
        o_entry.column = 12'(cur);
        o_entry.hc     = r_hc;
        o_entry.hr     = r_hr;
        o_entry.hd     = r_hd;
        o_entry.r_ok   = r_ok;
        o_entry.l_ok   = l_ok;
        if (r_is_flush) begin
            emit           = 1'b1;
            o_entry.row    = 12'(eff_h - 13'd1);
            o_entry.hu     = '0;
            o_entry.hl     = r_newer_q;
            o_entry.u_ok   = 1'b0;
            o_entry.d_ok   = 1'b1;
            o_entry.last   = !r_ok;
        end else begin
            emit           = (r_row != '0);
            o_entry.row    = 12'(r_row - 13'd1);
            o_entry.hu     = r_code;
            o_entry.hl     = r_hl;
            o_entry.u_ok   = 1'b1;
            o_entry.d_ok   = (r_row >= 13'd2);
            o_entry.last   = 1'b0;
        end
    end

    assign leave = (r_state == F_WRITE) && (!emit || !i_full);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept && go) n_state = F_READ0;
            F_READ0: n_state = F_READ1;
            F_READ1: n_state = F_READ2;
            F_READ2: n_state = F_WRITE;
            F_WRITE: if (leave) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall = (r_state != F_IDLE);
        o_push  = (r_state == F_WRITE) && emit && !i_full;
    end

    // Control state and raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_done  <= 1'b0;
            r_oc    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col  <= pre_col;
                r_row  <= pre_row;
                r_done <= pre_done;
            end
            if (leave) begin
                if (!r_is_flush) begin
                    if (cur_inc >= eff_w) begin
                        r_col <= '0;
                        r_row <= row_inc;
                        if (row_inc >= eff_h) begin
                            r_done <= 1'b1;
                        end
                    end else begin
                        r_col <= cur_inc;
                    end
                end else if (!r_ok) begin
                    r_oc   <= '0;
                    r_col  <= '0;
                    r_row  <= '0;
                    r_done <= 1'b0;
                end else begin
                    r_oc <= cur_inc;
                end
            end
        end
    end

    // Payload capture and neighbour gathering.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_flush <= i_command;
            r_code     <= code;
        end
        if (r_state == F_READ1) begin
            r_hc <= r_newer_q;
            r_hd <= r_older_q;
        end
        if (r_state == F_READ2) begin
            r_hr <= r_newer_q;
            r_hl <= r_older_q;
        end
    end

    // Row buffers: one read and one write each per cycle.
    always_ff @(posedge i_clk) begin
        r_newer_q <= r_newer_mem[newer_addr];
        r_older_q <= r_older_mem[older_addr];
        if (leave && !r_is_flush) begin
            r_older_mem[cur[AW-1:0]] <= r_hc;
            r_newer_mem[cur[AW-1:0]] <= r_code;
        end
    end

endmodule

FILE: src/hnm_queue.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator request queue
// Short queue of vertex requests between the front and back ends.
// ----------------------------------------------------------------------------
`include "heightmap_normal_generator_macros.svh"

module hnm_queue import hnm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_avail
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_entry        r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;

    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    `HNM_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, (r_count != NW'(QUEUE_DEPTH)), "request pushed into a full queue")
    `HNM_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, (r_count != '0), "request popped from an empty queue")

endmodule

FILE: src/hnm_back.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator back end
// Sums the neighbour cross products, normalizes the result with a serial
// square root and a serial divider, and holds the vertex in an output
// register.
// ----------------------------------------------------------------------------
`include "heightmap_normal_generator_macros.svh"

module hnm_back import hnm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_avail,
    input  t_entry             i_entry,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [11:0] o_column,
    output logic        [11:0] o_row,
    output logic        [23:0] o_height_value,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic               o_last_vertex
);

    // Magnitude width of the raw normal sum.
    localparam int MW = 52;

    t_back_state r_state, n_state;

    t_entry             r_ent;
    logic signed [10:0] r_wa, r_wb;
    logic [2:0]         r_terms;
    logic signed [27:0] r_pa, r_pb;
    logic [31:0]        r_pxz;
    logic [23:0]        r_height;
    logic [MW-1:0]      r_mag [3];
    logic [2:0]         r_neg;
    logic [1:0]         r_step;
    logic [59:0]        r_sq;
    logic [61:0]        r_acc;
    logic [61:0]        r_v;
    logic [62:0]        r_root, r_bit;
    logic [1:0]         r_comp;
    logic [31:0]        r_rem;
    logic [15:0]        r_numlo, r_quo;
    logic [3:0]         r_dcnt;
    logic [15:0]        r_norm [3];
    logic               r_out_valid;

    logic signed [10:0] wr, wl, wu, wd;
    logic [1:0]         nr, nl, nu, nd;
    logic signed [44:0] prod0, prod2;
    logic [44:0]        abs0, abs2;
    logic               any_big, out_free, out_load;
    logic [29:0]        sq_sel, div_sel;
    logic [61:0]        acc_sum;
    logic [62:0]        sq_t;
    logic               sq_ge;
    logic [31:0]        len;
    logic [45:0]        num;
    logic [32:0]        rem2;
    logic               div_ge;
    logic [15:0]        q_fin, q_sat;
    logic               q_neg;

    // Height difference times its term count.
    function automatic logic signed [10:0] weighted(input logic [7:0] hn,
                                                    input logic [7:0] hc,
                                                    input logic [1:0] n);
        logic signed [8:0] d;
        d = $signed({1'b0, hn}) - $signed({1'b0, hc});
        case (n)
            2'd1:    weighted = 11'(d);
            2'd2:    weighted = 11'(d) <<< 1;
            default: weighted = '0;
        endcase
    endfunction

    // Per-direction term counts.
    always_comb begin
        nr = r_ent.r_ok ? ({1'b0, r_ent.u_ok} + {1'b0, r_ent.d_ok}) : 2'd0;
        nl = r_ent.l_ok ? ({1'b0, r_ent.u_ok} + {1'b0, r_ent.d_ok}) : 2'd0;
        nu = r_ent.u_ok ? ({1'b0, r_ent.r_ok} + {1'b0, r_ent.l_ok}) : 2'd0;
        nd = r_ent.d_ok ? ({1'b0, r_ent.r_ok} + {1'b0, r_ent.l_ok}) : 2'd0;
        wr = weighted(r_ent.hr, r_ent.hc, nr);
        wl = weighted(r_ent.hl, r_ent.hc, nl);
        wu = weighted(r_ent.hu, r_ent.hc, nu);
        wd = weighted(r_ent.hd, r_ent.hc, nd);
    end

    // Second product stage: the normal is the negated sum.
    assign prod0 = r_pa * $signed({1'b0, i_cfg.step_z});
    assign prod2 = r_pb * $signed({1'b0, i_cfg.step_x});
    assign abs0  = prod0[44] ? 45'(-prod0) : 45'(prod0);
    assign abs2  = prod2[44] ? 45'(-prod2) : 45'(prod2);

    assign any_big = (r_mag[0][MW-1:30] != '0) || (r_mag[1][MW-1:30] != '0)
                     || (r_mag[2][MW-1:30] != '0);

    // Component selects for the squarer and the divider.
    always_comb begin
        case (r_step)
            2'd0:    sq_sel = r_mag[0][29:0];
            2'd1:    sq_sel = r_mag[1][29:0];
            default: sq_sel = r_mag[2][29:0];
        endcase
        case (r_comp)
            2'd0:    begin div_sel = r_mag[0][29:0]; q_neg = r_neg[0]; end
            2'd1:    begin div_sel = r_mag[1][29:0]; q_neg = r_neg[1]; end
            default: begin div_sel = r_mag[2][29:0]; q_neg = r_neg[2]; end
        endcase
    end

    assign acc_sum = r_acc + {2'b0, r_sq};

    // One step of the square root.
    assign sq_t  = r_root + r_bit;
    assign sq_ge = ({1'b0, r_v} >= sq_t);
    assign len   = r_root[31:0];

    // One step of the divider, rounded numerator.
    assign num    = {1'b0, div_sel, 15'b0} + {15'b0, len[31:1]};
    assign rem2   = {r_rem, r_numlo[15]};
    assign div_ge = (rem2 >= {1'b0, len});
    assign q_fin  = {r_quo[14:0], div_ge};

    // Sign restore with saturation.
    always_comb begin
        if (len == '0) begin
            q_sat = '0;
        end else if (q_neg) begin
            q_sat = (q_fin > 16'd32768) ? 16'd32768 : 16'(17'd65536 - {1'b0, q_fin});
            if (q_fin > 16'd32768) begin
                q_sat = 16'd32768;
            end
        end else begin
            q_sat = (q_fin > 16'd32767) ? 16'd32767 : q_fin;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:   if (i_avail) n_state = B_DIFF;
            B_DIFF:   n_state = B_MUL1;
            B_MUL1:   n_state = B_MUL2;
            B_MUL2:   n_state = B_SHIFT;
            B_SHIFT:  if (!any_big) n_state = B_SQUARE;
            B_SQUARE: if (r_step == 2'd3) n_state = B_SQRT;
            B_SQRT:   if (r_bit[0]) n_state = B_DLOAD;
            B_DLOAD:  n_state = B_DIV;
            B_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = (r_comp == 2'd2) ? B_DONE : B_DLOAD;
                end
            end
            B_DONE:   if (out_free) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        o_pop    = (r_state == B_IDLE) && i_avail;
        out_load = (r_state == B_DONE) && out_free;
    end

    // Control state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_avail) begin
                    r_ent <= i_entry;
                end
            end
            B_DIFF: begin
                r_wa    <= wr - wl;
                r_wb    <= wu - wd;
                r_terms <= {2'b0, r_ent.u_ok & r_ent.r_ok} + {2'b0, r_ent.d_ok & r_ent.r_ok}
                           + {2'b0, r_ent.d_ok & r_ent.l_ok} + {2'b0, r_ent.u_ok & r_ent.l_ok};
            end
            B_MUL1: begin
                r_pa     <= r_wa * $signed({1'b0, i_cfg.height_step});
                r_pb     <= r_wb * $signed({1'b0, i_cfg.height_step});
                r_pxz    <= 32'(i_cfg.step_x) * 32'(i_cfg.step_z);
                r_height <= 24'(r_ent.hc) * 24'(i_cfg.height_step);
            end
            B_MUL2: begin
                r_mag[0] <= {abs0[43:0], 8'b0};
                r_mag[1] <= MW'({3'b0, r_pxz} * {32'b0, r_terms});
                r_mag[2] <= {abs2[43:0], 8'b0};
                r_neg[0] <= !prod0[44] && (prod0 != '0);
                r_neg[1] <= 1'b0;
                r_neg[2] <= !prod2[44] && (prod2 != '0);
                r_step   <= '0;
                r_acc    <= '0;
            end
            B_SHIFT: begin
                if (any_big) begin
                    r_mag[0] <= r_mag[0] >> 1;
                    r_mag[1] <= r_mag[1] >> 1;
                    r_mag[2] <= r_mag[2] >> 1;
                end
            end
            B_SQUARE: begin
                if (r_step != 2'd3) begin
                    r_sq <= sq_sel * sq_sel;
                end
                if (r_step != 2'd0) begin
                    r_acc <= acc_sum;
                end
                r_step <= r_step + 2'd1;
                r_v    <= acc_sum;
                r_root <= '0;
                r_bit  <= {1'b1, 62'b0};
            end
            B_SQRT: begin
                if (sq_ge) begin
                    r_v    <= r_v - 62'(sq_t);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_comp <= '0;
            end
            B_DLOAD: begin
                r_rem   <= {2'b0, num[45:16]};
                r_numlo <= num[15:0];
                r_quo   <= '0;
                r_dcnt  <= 4'd15;
            end
            B_DIV: begin
                r_rem   <= div_ge ? 32'(rem2 - {1'b0, len}) : 32'(rem2);
                r_quo   <= q_fin;
                r_numlo <= r_numlo << 1;
                r_dcnt  <= r_dcnt - 4'd1;
                if (r_dcnt == '0) begin
                    case (r_comp)
                        2'd0:    r_norm[0] <= q_sat;
                        2'd1:    r_norm[1] <= q_sat;
                        default: r_norm[2] <= q_sat;
                    endcase
                    r_comp <= r_comp + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            o_column       <= r_ent.column;
            o_row          <= r_ent.row;
            o_height_value <= r_height;
            o_normal_x     <= r_norm[0];
            o_normal_y     <= r_norm[1];
            o_normal_z     <= r_norm[2];
            o_last_vertex  <= r_ent.last;
        end
    end

    assign o_out_valid = r_out_valid;

    `HNM_ASSERT_SAME(a_norm_range, i_clk, i_rst_n, (r_state == B_SQUARE), (!any_big), "normal components not reduced below 2^30")
    `HNM_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, r_out_valid, "finished vertex not presented")

endmodule

FILE: src/heightmap_normal_generator.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator
// Turns a raster stream of RGBA heightmap texels into vertices with height
// and unit normal.
//
// Input channel: i_in_valid / o_in_stall with i_command and i_texel. A texel
// request carries the next pixel in raster order; a flush request releases
// one vertex of the last row once the whole map has arrived.
// Output channel: o_out_valid / i_out_stall; row 0 texels give no vertex.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index and
// i_cfg_data; write only while no vertex is in flight.
// The front end serves one request at a time: an accept step, three row
// buffer read steps and a write step that waits on a full queue; ignored
// requests do not stall the input. The back end serves one vertex at a time
// with a serial normalize shift, a 32-step square root and three serial
// divisions, which set the sustained rate. A two-entry queue lets the front
// keep accepting while the back end works or the receiver stalls; a stalled
// vertex holds in the output register. Reset clears counters, queue and
// registers to defaults; row buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module heightmap_normal_generator import hnm_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [31:0]            i_texel,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [11:0]            o_column,
    output logic [11:0]            o_row,
    output logic [23:0]            o_height_value,
    output logic signed [15:0]     o_normal_x,
    output logic signed [15:0]     o_normal_y,
    output logic signed [15:0]     o_normal_z,
    output logic                   o_last_vertex,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg   r_cfg;
    t_entry front_entry, queue_entry;
    logic   push, full, pop, avail;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width      <= RST_MAP_WIDTH;
            r_cfg.map_height     <= RST_MAP_HEIGHT;
            r_cfg.channel_select <= RST_CHANNEL_SELECT;
            r_cfg.height_step    <= RST_HEIGHT_STEP;
            r_cfg.step_x         <= RST_STEP_X;
            r_cfg.step_z         <= RST_STEP_Z;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH:      r_cfg.map_width      <= i_cfg_data[12:0];
                CFG_MAP_HEIGHT:     r_cfg.map_height     <= i_cfg_data[12:0];
                CFG_CHANNEL_SELECT: r_cfg.channel_select <= i_cfg_data[1:0];
                CFG_HEIGHT_STEP:    r_cfg.height_step    <= i_cfg_data;
                CFG_STEP_X:         r_cfg.step_x         <= i_cfg_data;
                CFG_STEP_Z:         r_cfg.step_z         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hnm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_command (i_command),
        .i_texel   (i_texel),
        .o_push    (push),
        .o_entry   (front_entry),
        .i_full    (full)
    );

    hnm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_avail (avail)
    );

    hnm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_avail        (avail),
        .i_entry        (queue_entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_height_value (o_height_value),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_last_vertex  (o_last_vertex)
    );

endmodule
